// File: sv/scs_pkg.sv
`default_nettype none
package scs_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LAME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR = 2'd1;

  // Job queue between the front and the back.
  localparam int QD     = 16;
  localparam int QPTR_W = $clog2(QD);
  localparam int QCNT_W = $clog2(QD + 1);

  // Width of one exact F S F^T element and number of quotient bits.
  localparam int T_W       = 98;
  localparam int DIV_STEPS = 47;

  typedef struct packed {
    logic signed [31:0] f_xx;
    logic signed [31:0] f_xy;
    logic signed [31:0] f_xz;
    logic signed [31:0] f_yx;
    logic signed [31:0] f_yy;
    logic signed [31:0] f_yz;
    logic signed [31:0] f_zx;
    logic signed [31:0] f_zy;
    logic signed [31:0] f_zz;
  } in_t;

  typedef struct packed {
    logic signed [47:0] sigma_xx;
    logic signed [47:0] sigma_yy;
    logic signed [47:0] sigma_zz;
    logic signed [47:0] sigma_xy;
    logic signed [47:0] sigma_yz;
    logic signed [47:0] sigma_xz;
    logic               bad_volume;
  } out_t;

  // One divide job: six numerators, the determinant and the volume flag.
  typedef struct packed {
    logic [5:0][T_W-1:0] t;
    logic [63:0]         det;
    logic                bad;
  } job_t;

endpackage
`default_nettype wire

// File: sv/scs_front.sv
`default_nettype none
module scs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  scs_pkg::in_t  in_data,
  input  logic [31:0]   lame,
  input  logic [31:0]   shear,
  output logic          job_valid,
  output scs_pkg::job_t job
);
  import scs_pkg::*;

  // Symmetric element e covers row erow(e), column ecol(e):
  // xx, yy, zz, xy, yz, xz.
  function automatic int erow(input int e);
    case (e)
      0: erow = 0;
      1: erow = 1;
      2: erow = 2;
      3: erow = 0;
      4: erow = 1;
      default: erow = 0;
    endcase
  endfunction

  function automatic int ecol(input int e);
    case (e)
      0: ecol = 0;
      1: ecol = 1;
      2: ecol = 2;
      3: ecol = 1;
      4: ecol = 2;
      default: ecol = 2;
    endcase
  endfunction

  function automatic int pidx(input int i, input int j);
    if (i == j) pidx = i;
    else if (i + j == 1) pidx = 3;
    else if (i + j == 3) pidx = 4;
    else pidx = 5;
  endfunction

  logic [8:0] v_r;
  logic signed [31:0] f_r [7][9];

  logic signed [39:0] p1_r [6][3];
  logic signed [35:0] mp1_r [6];
  logic signed [43:0] d2_r [6];
  logic signed [45:0] tr2_r;
  logic signed [36:0] m2_r [3];
  logic signed [55:0] lsh3_r;
  logic signed [55:0] lsl3_r;
  logic signed [55:0] msh3_r [6];
  logic signed [55:0] msl3_r [6];
  logic signed [68:0] dp3_r [3];
  logic signed [63:0] s4_r [6];
  logic [63:0]        det_r [4:8];
  logic               bad_r [4:8];
  logic signed [63:0] gph5_r [9][3];
  logic signed [64:0] gpl5_r [9][3];
  logic signed [63:0] g6_r [9];
  logic signed [63:0] tph7_r [6][3];
  logic signed [64:0] tpl7_r [6][3];
  logic [5:0][T_W-1:0] t8_r;

  logic signed [63:0] sp_c [6][3];
  logic signed [63:0] mp_c [6];
  logic signed [43:0] d_c [6];
  logic signed [45:0] tr_c;
  logic signed [36:0] m_c [3];
  logic signed [55:0] lsh_c;
  logic signed [55:0] lsl_c;
  logic signed [55:0] msh_c [6];
  logic signed [55:0] msl_c [6];
  logic signed [68:0] dp_c [3];
  logic signed [80:0] sacc_c [6];
  logic signed [70:0] dacc_c;
  logic signed [63:0] det_c;
  logic signed [63:0] gph_c [9][3];
  logic signed [64:0] gpl_c [9][3];
  logic signed [65:0] gh_c [9];
  logic signed [66:0] gl_c [9];
  logic signed [65:0] gs_c [9];
  logic signed [63:0] tph_c [6][3];
  logic signed [64:0] tpl_c [6][3];
  logic signed [97:0] ts_c [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[7:0], in_valid};
    end
  end

  always_comb begin
    // Products for F^T F (one per term) and for the cofactor minors.
    for (int e = 0; e < 6; e++) begin
      for (int k = 0; k < 3; k++) begin
        sp_c[e][k] = f_r[0][3*k + erow(e)] * f_r[0][3*k + ecol(e)];
      end
    end
    mp_c[0] = f_r[0][4] * f_r[0][8];
    mp_c[1] = f_r[0][5] * f_r[0][7];
    mp_c[2] = f_r[0][3] * f_r[0][8];
    mp_c[3] = f_r[0][5] * f_r[0][6];
    mp_c[4] = f_r[0][3] * f_r[0][7];
    mp_c[5] = f_r[0][4] * f_r[0][6];

    // D = 2E in Q.32.
    for (int e = 0; e < 6; e++) begin
      d_c[e] = p1_r[e][0] + p1_r[e][1] + p1_r[e][2];
      if (e < 3) d_c[e] = d_c[e] - 44'sh1_0000_0000;
    end
    tr_c = d_c[0] + d_c[1] + d_c[2];
    for (int n = 0; n < 3; n++) begin
      m_c[n] = mp1_r[2*n] - mp1_r[2*n + 1];
    end

    // Wide products are split into a signed upper and an unsigned lower
    // part; the parts are recombined in the following stage.
    lsh_c = $signed({1'b0, lame}) * $signed(tr2_r[45:23]);
    lsl_c = $signed({1'b0, lame}) * $signed({1'b0, tr2_r[22:0]});
    for (int e = 0; e < 6; e++) begin
      msh_c[e] = $signed({1'b0, shear}) * $signed(d2_r[e][43:22]);
      msl_c[e] = $signed({1'b0, shear}) * $signed({1'b0, d2_r[e][21:0]});
    end
    for (int n = 0; n < 3; n++) begin
      dp_c[n] = f_r[2][n] * m2_r[n];
    end

    for (int e = 0; e < 6; e++) begin
      sacc_c[e] = (81'(msh3_r[e]) <<< 23) + (81'(msl3_r[e]) <<< 1);
      if (e < 3) sacc_c[e] = sacc_c[e] + (81'(lsh3_r) <<< 23) + 81'(lsl3_r);
    end
    dacc_c = dp3_r[0] - dp3_r[1] + dp3_r[2];
    det_c  = dacc_c[69:6];

    for (int i = 0; i < 3; i++) begin
      for (int l = 0; l < 3; l++) begin
        for (int k = 0; k < 3; k++) begin
          gph_c[3*i + l][k] = f_r[4][3*i + k] * $signed(s4_r[pidx(k, l)][63:32]);
          gpl_c[3*i + l][k] = f_r[4][3*i + k] * $signed({1'b0, s4_r[pidx(k, l)][31:0]});
        end
      end
    end
    for (int n = 0; n < 9; n++) begin
      gh_c[n] = 66'(gph5_r[n][0]) + 66'(gph5_r[n][1]) + 66'(gph5_r[n][2]);
      gl_c[n] = 67'(gpl5_r[n][0]) + 67'(gpl5_r[n][1]) + 67'(gpl5_r[n][2]);
      gs_c[n] = gh_c[n] + 66'(gl_c[n] >>> 32);
    end

    for (int e = 0; e < 6; e++) begin
      for (int l = 0; l < 3; l++) begin
        tph_c[e][l] = $signed(g6_r[3*erow(e) + l][63:32]) * f_r[6][3*ecol(e) + l];
        tpl_c[e][l] = $signed({1'b0, g6_r[3*erow(e) + l][31:0]}) * f_r[6][3*ecol(e) + l];
      end
      ts_c[e] = ((98'(tph7_r[e][0]) + 98'(tph7_r[e][1]) + 98'(tph7_r[e][2])) <<< 32)
              + 98'(tpl7_r[e][0]) + 98'(tpl7_r[e][1]) + 98'(tpl7_r[e][2]);
    end
  end

  always_ff @(posedge clk) begin
    f_r[0][0] <= in_data.f_xx;
    f_r[0][1] <= in_data.f_xy;
    f_r[0][2] <= in_data.f_xz;
    f_r[0][3] <= in_data.f_yx;
    f_r[0][4] <= in_data.f_yy;
    f_r[0][5] <= in_data.f_yz;
    f_r[0][6] <= in_data.f_zx;
    f_r[0][7] <= in_data.f_zy;
    f_r[0][8] <= in_data.f_zz;
    for (int s = 1; s < 7; s++) begin
      for (int n = 0; n < 9; n++) begin
        f_r[s][n] <= f_r[s-1][n];
      end
    end

    for (int e = 0; e < 6; e++) begin
      for (int k = 0; k < 3; k++) begin
        p1_r[e][k] <= sp_c[e][k][63:24];
      end
      mp1_r[e] <= mp_c[e][63:28];
    end

    d2_r  <= d_c;
    tr2_r <= tr_c;
    m2_r  <= m_c;

    lsh3_r <= lsh_c;
    lsl3_r <= lsl_c;
    msh3_r <= msh_c;
    msl3_r <= msl_c;
    dp3_r  <= dp_c;

    for (int e = 0; e < 6; e++) begin
      s4_r[e] <= sacc_c[e][80:17];
    end
    det_r[4] <= det_c;
    bad_r[4] <= (det_c <= 64'sd0);
    for (int s = 5; s < 9; s++) begin
      det_r[s] <= det_r[s-1];
      bad_r[s] <= bad_r[s-1];
    end

    gph5_r <= gph_c;
    gpl5_r <= gpl_c;
    for (int n = 0; n < 9; n++) begin
      g6_r[n] <= gs_c[n][63:0];
    end
    tph7_r <= tph_c;
    tpl7_r <= tpl_c;
    for (int e = 0; e < 6; e++) begin
      t8_r[e] <= ts_c[e];
    end
  end

  assign job_valid = v_r[8];
  assign job.t     = t8_r;
  assign job.det   = det_r[8];
  assign job.bad   = bad_r[8];

endmodule
`default_nettype wire

// File: sv/scs_queue.sv
`default_nettype none
module scs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  scs_pkg::job_t din,
  input  logic          pop,
  output logic          empty,
  output scs_pkg::job_t dout
);
  import scs_pkg::*;

  job_t              mem_r [QD];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // The front only issues a job when it holds a credit, so push never meets
  // a full queue.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop)  rd_r <= rd_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

endmodule
`default_nettype wire

// File: sv/scs_back.sv
`default_nettype none
module scs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_avail,
  input  scs_pkg::job_t job,
  output logic          job_take,
  output logic          out_empty,
  input  logic          out_pop,
  output scs_pkg::out_t out_data
);
  import scs_pkg::*;

  localparam int NST = DIV_STEPS + 1;

  logic [NST-1:0] v_r;
  logic [62:0]    d_r   [NST];
  logic           bad_r [NST];
  logic [62:0]    r_r   [NST][6];
  logic [46:0]    nb_r  [NST][6];
  logic [46:0]    q_r   [NST][6];
  logic           neg_r [NST][6];
  logic           sat_r [NST][6];

  out_t out_r;
  logic out_v_r;
  logic adv;

  logic signed [116:0] num_c [6];
  logic [116:0]        mag_c [6];
  logic [63:0]         rr_c  [NST][6];
  logic                ge_c  [NST][6];
  logic signed [47:0]  res_c [6];
  out_t                out_c;

  // Every stage moves when the output register is free or being drained.
  assign adv      = !out_v_r || out_pop;
  assign job_take = adv && job_avail;

  always_comb begin
    for (int e = 0; e < 6; e++) begin
      num_c[e] = $signed(job.t[e]);
      num_c[e] = num_c[e] <<< 18;
      mag_c[e] = num_c[e][116] ? -num_c[e] : num_c[e];
    end

    for (int s = 1; s < NST; s++) begin
      for (int e = 0; e < 6; e++) begin
        rr_c[s][e] = {r_r[s-1][e], nb_r[s-1][e][46]};
        ge_c[s][e] = rr_c[s][e] >= {1'b0, d_r[s-1]};
      end
    end
    for (int e = 0; e < 6; e++) begin
      rr_c[0][e] = '0;
      ge_c[0][e] = 1'b0;
    end

    for (int e = 0; e < 6; e++) begin
      if (bad_r[NST-1]) begin
        res_c[e] = '0;
      end else if (sat_r[NST-1][e]) begin
        res_c[e] = neg_r[NST-1][e] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else if (neg_r[NST-1][e]) begin
        res_c[e] = 48'd0 - {1'b0, q_r[NST-1][e]};
      end else begin
        res_c[e] = {1'b0, q_r[NST-1][e]};
      end
    end
    out_c.sigma_xx   = res_c[0];
    out_c.sigma_yy   = res_c[1];
    out_c.sigma_zz   = res_c[2];
    out_c.sigma_xy   = res_c[3];
    out_c.sigma_yz   = res_c[4];
    out_c.sigma_xz   = res_c[5];
    out_c.bad_volume = bad_r[NST-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[NST-2:0], job_take};
      out_v_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r[0]   <= job.det[62:0];
      bad_r[0] <= job.bad;
      for (int e = 0; e < 6; e++) begin
        // A quotient at or above 2^47 saturates; otherwise the top part of
        // the magnitude is already below the divisor.
        sat_r[0][e] <= mag_c[e] >= {7'd0, job.det[62:0], 47'd0};
        neg_r[0][e] <= num_c[e][116];
        r_r[0][e]   <= mag_c[e][109:47];
        nb_r[0][e]  <= mag_c[e][46:0];
        q_r[0][e]   <= '0;
      end
      for (int s = 1; s < NST; s++) begin
        d_r[s]   <= d_r[s-1];
        bad_r[s] <= bad_r[s-1];
        for (int e = 0; e < 6; e++) begin
          sat_r[s][e] <= sat_r[s-1][e];
          neg_r[s][e] <= neg_r[s-1][e];
          r_r[s][e]   <= ge_c[s][e] ? 63'(rr_c[s][e] - {1'b0, d_r[s-1]})
                                    : rr_c[s][e][62:0];
          nb_r[s][e]  <= {nb_r[s-1][e][45:0], 1'b0};
          q_r[s][e]   <= {q_r[s-1][e][45:0], ge_c[s][e]};
        end
      end
      out_r <= out_c;
    end
  end

  assign out_empty = !out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: sv/svk_cauchy_stress.sv
`default_nettype none
// Channel  Ports                          Moves
// in       in_push, in_full, in_data      one deformation gradient F
// out      out_pop, out_empty, out_data   six Cauchy stresses and bad_volume
// cfg      cfg_we, cfg_idx, cfg_data      lame_first, shear_modulus
//
// One transaction is accepted per cycle while in_full is low. A transaction
// passes through the multiply pipeline, the job queue, and the pipelined
// restoring dividers plus the output register; the 47-stage restoring divider
// in the back end sets the latency.
// Reset is synchronous; it empties both pipelines and the queue and clears
// the moduli. A stalled output freezes the back end only; the front keeps
// accepting until its queue credits run out.
module svk_cauchy_stress (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  scs_pkg::in_t                   in_data,
  output logic                           out_empty,
  input  logic                           out_pop,
  output scs_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [31:0]                    cfg_data
);
  import scs_pkg::*;

  logic [31:0]       lame_r, shear_r;
  logic [QCNT_W-1:0] cred_r, cred_nxt;
  logic              accept;
  logic              job_valid, q_empty, q_pop;
  job_t              job_in, job_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lame_r  <= '0;
      shear_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LAME:  lame_r  <= cfg_data;
        REG_SHEAR: shear_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Credits cover every transaction in the front pipeline or in the queue.
  assign in_full = (cred_r == QCNT_W'(QD));
  assign accept  = in_push && !in_full;

  always_comb begin
    cred_nxt = cred_r;
    if (accept && !q_pop) cred_nxt = cred_r + QCNT_W'(1);
    if (!accept && q_pop) cred_nxt = cred_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else begin
      cred_r <= cred_nxt;
    end
  end

  scs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .lame      (lame_r),
    .shear     (shear_r),
    .job_valid (job_valid),
    .job       (job_in)
  );

  scs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_valid),
    .din   (job_in),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (job_out)
  );

  scs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!q_empty),
    .job       (job_out),
    .job_take  (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
